// File: hw/rtl/psfp_pkg.sv
// Shared constants and controller/datapath interface types for the frame parser.
package psfp_pkg;

    localparam int PSFP_FRAME_BYTES = 32;
    localparam logic [7:0] PSFP_START_BYTE = 8'h42;

    typedef struct packed {
        logic accept;       // input byte transaction this cycle
        logic start_drain;  // clear read index, begin data word output
        logic load_word;    // load output register from word store
        logic load_err;     // load output register with checksum error result
        logic next_word;    // advance read index
    } psfp_cmd_t;

    typedef struct packed {
        logic final_byte;   // current byte closes the frame
        logic csum_ok;      // running sum equals received checksum word
        logic rd_last;      // read index is on the last data word
        logic out_last;     // output register holds the last result
    } psfp_sts_t;

endpackage

// File: hw/rtl/psfp_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module psfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 14
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/psfp_dp.sv
// Datapath: byte position, running sum, word assembly, word store and output register.
module psfp_dp #(
    parameter int FRAME_BYTES = psfp_pkg::PSFP_FRAME_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  psfp_pkg::psfp_cmd_t   cmd,
    output psfp_pkg::psfp_sts_t   sts,
    input  logic [7:0]            s_rx_byte,
    output logic [3:0]            m_word_index,
    output logic [15:0]           m_word_value,
    output logic                  m_frame_ok,
    output logic                  m_last
);

    import psfp_pkg::*;

    localparam int DATA_WORDS = (FRAME_BYTES - 4) / 2;
    localparam int AW = $clog2(DATA_WORDS);
    localparam logic [5:0] POS_FINAL = 6'(FRAME_BYTES - 1);
    localparam logic [5:0] POS_SUM_END = 6'(FRAME_BYTES - 2);
    localparam logic [5:0] N_WORDS = 6'(DATA_WORDS);
    localparam logic [AW-1:0] LAST_IDX = AW'(DATA_WORDS - 1);
    localparam logic [3:0] ERR_INDEX = 4'(DATA_WORDS);

    logic [5:0]    pos_reg, pos_next;
    logic [15:0]   sum_reg, sum_next;
    logic [7:0]    pend_reg, pend_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [3:0]    idx_out_reg;
    logic [15:0]   val_out_reg;
    logic          ok_out_reg;
    logic          last_out_reg;

    logic [7:0]    check_hi;
    logic [15:0]   check_word;
    logic [5:0]    word_num;
    logic          wr_en;
    logic [15:0]   rd_data;
    logic [5:0]    rd_idx_ext;

    // On an even final position the high byte is this byte itself.
    assign check_hi   = pos_reg[0] ? pend_reg : s_rx_byte;
    assign check_word = {check_hi, s_rx_byte};
    assign word_num   = (pos_reg - 6'd3) >> 1;
    assign wr_en      = cmd.accept && pos_reg[0] && (pos_reg >= 6'd3) && (word_num < N_WORDS);
    assign rd_idx_ext = 6'(rd_idx_reg);

    assign sts.final_byte = (pos_reg >= POS_FINAL);
    assign sts.csum_ok    = (check_word == sum_reg);
    assign sts.rd_last    = (rd_idx_reg == LAST_IDX);
    assign sts.out_last   = last_out_reg;

    always_comb begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        pend_next = pend_reg;
        if (cmd.accept) begin
            if (pos_reg == 6'd0) begin
                if (s_rx_byte == PSFP_START_BYTE) begin
                    sum_next = 16'(s_rx_byte);
                    pos_next = 6'd1;
                end
            end else begin
                if (pos_reg < POS_SUM_END) begin
                    sum_next = sum_reg + 16'(s_rx_byte);
                end
                if (pos_reg >= 6'd2 && !pos_reg[0]) begin
                    pend_next = s_rx_byte;
                end
                pos_next = sts.final_byte ? 6'd0 : pos_reg + 6'd1;
            end
        end
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.start_drain) begin
            rd_idx_next = '0;
        end else if (cmd.next_word) begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            pend_reg   <= '0;
            rd_idx_reg <= '0;
        end else begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            pend_reg   <= pend_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_err) begin
            idx_out_reg  <= ERR_INDEX;
            val_out_reg  <= check_word;
            ok_out_reg   <= 1'b0;
            last_out_reg <= 1'b1;
        end else if (cmd.load_word) begin
            idx_out_reg  <= rd_idx_ext[3:0];
            val_out_reg  <= rd_data;
            ok_out_reg   <= 1'b1;
            last_out_reg <= sts.rd_last;
        end
    end

    psfp_ram #(
        .WIDTH (16),
        .DEPTH (DATA_WORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (word_num[AW-1:0]),
        .wdata ({pend_reg, s_rx_byte}),
        .raddr (rd_idx_reg),
        .rdata (rd_data)
    );

    assign m_word_index = idx_out_reg;
    assign m_word_value = val_out_reg;
    assign m_frame_ok   = ok_out_reg;
    assign m_last       = last_out_reg;

`ifndef NO_ASSERTIONS
    a_rd_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_idx_ext < N_WORDS)
        else $error("read index beyond word store");
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_err |=> (!ok_out_reg && last_out_reg && idx_out_reg == ERR_INDEX))
        else $error("error result not flagged as failed last result");
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_FINAL)
        else $error("byte position past end of frame");
`endif

endmodule

// File: hw/rtl/psfp_ctrl.sv
// Controller state machine: byte reception, word store drain and result handshake.
module psfp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  psfp_pkg::psfp_sts_t  sts,
    output psfp_pkg::psfp_cmd_t  cmd
);

    import psfp_pkg::*;

    localparam logic [1:0] ST_RX  = 2'd0;  // taking bytes
    localparam logic [1:0] ST_RD  = 2'd1;  // store read issued
    localparam logic [1:0] ST_LD  = 2'd2;  // read data to output register
    localparam logic [1:0] ST_OUT = 2'd3;  // result presented

    logic [1:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_RX);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.accept      = s_valid && s_ready;
        unique case (state_reg)
            ST_RX: begin
                if (cmd.accept && sts.final_byte) begin
                    if (sts.csum_ok) begin
                        cmd.start_drain = 1'b1;
                        state_next      = ST_RD;
                    end else begin
                        cmd.load_err = 1'b1;
                        state_next   = ST_OUT;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_LD;
            end
            ST_LD: begin
                cmd.load_word = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (sts.out_last) begin
                        state_next = ST_RX;
                    end else begin
                        cmd.next_word = 1'b1;
                        state_next    = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_RX;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RX;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output both open");
    a_back_to_rx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && sts.out_last) |=> s_ready)
        else $error("no return to reception after last result");
    a_drain_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !sts.out_last) |=> (state_reg == ST_RD))
        else $error("drain did not continue after non-last result");
`endif

endmodule

// File: hw/rtl/particle_sensor_frame_parser_top.sv
// Top level of the particle sensor frame parser.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_rx_byte[7:0]
//  m_       out        m_valid / m_ready    m_word_index[3:0] m_word_value[15:0]
//                                           m_frame_ok m_last
//
// Bytes are taken one per cycle while a frame is being received or hunted.
// After the closing byte of a good frame, each data word goes through a store read,
// an output load and presentation, plus any wait on m_ready; the store read step
// is needed because the word store has a single registered read port.
// A bad frame gives one result in the cycle after its closing byte.
// No input is taken while results are being delivered. aresetn is
// synchronous, active low, and puts the parser into start-byte hunt.
module particle_sensor_frame_parser_top #(
    parameter int FRAME_BYTES = psfp_pkg::PSFP_FRAME_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_word_index,
    output logic [15:0] m_word_value,
    output logic        m_frame_ok,
    output logic        m_last
);

    import psfp_pkg::*;

    psfp_cmd_t cmd;
    psfp_sts_t sts;

    psfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    psfp_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_rx_byte    (s_rx_byte),
        .m_word_index (m_word_index),
        .m_word_value (m_word_value),
        .m_frame_ok   (m_frame_ok),
        .m_last       (m_last)
    );

endmodule

// File: verif/tb_particle_sensor_frame_parser_top.sv
// Self-checking testbench for the particle sensor frame parser top level.
module tb_particle_sensor_frame_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import psfp_pkg::*;

    localparam int FB           = PSFP_FRAME_BYTES;
    localparam int DATA_WORDS   = (FB - 4) / 2;
    localparam logic [7:0] SECOND_HDR = 8'h4D;
    localparam int TOTAL_ITEMS  = 470;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [3:0]  word_index;
        logic [15:0] word_value;
        logic        frame_ok;
        logic        last;
    } frame_word_t;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_START} fill_t;
    typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_LONG_STALL} rx_mode_t;

    class frame_word_scoreboard;
        logic [5:0]  rx_pos = '0;
        logic [15:0] csum_acc = '0;
        logic [7:0]  hi_byte = '0;
        logic [15:0] data_words[DATA_WORDS];
        frame_word_t expected_words[$];
        int          mismatches = 0;

        // Track one accepted byte and queue whatever words it releases.
        function void note_byte(logic [7:0] b);
            int          w;
            logic [15:0] rx_csum;
            frame_word_t fw;
            if (rx_pos == 0) begin
                if (b == PSFP_START_BYTE) begin
                    csum_acc = 16'(b);
                    rx_pos   = 6'd1;
                end
                return;
            end
            if (rx_pos < FB - 2) csum_acc = csum_acc + 16'(b);
            if (rx_pos >= 2) begin
                if (!rx_pos[0]) begin
                    hi_byte = b;
                end else begin
                    w = (int'(rx_pos) - 3) / 2;
                    if (w < DATA_WORDS) data_words[w] = {hi_byte, b};
                end
            end
            if (rx_pos >= FB - 1) begin
                rx_csum = {hi_byte, b};
                rx_pos  = '0;
                if (rx_csum == csum_acc) begin
                    for (int i = 0; i < DATA_WORDS; i++) begin
                        fw.word_index = 4'(i);
                        fw.word_value = data_words[i];
                        fw.frame_ok   = 1'b1;
                        fw.last       = (i == DATA_WORDS - 1);
                        expected_words.push_back(fw);
                    end
                end else begin
                    fw.word_index = 4'(DATA_WORDS);
                    fw.word_value = rx_csum;
                    fw.frame_ok   = 1'b0;
                    fw.last       = 1'b1;
                    expected_words.push_back(fw);
                end
                return;
            end
            rx_pos = rx_pos + 6'd1;
        endfunction

        function void check_word(logic [3:0] idx, logic [15:0] val, logic ok, logic last);
            frame_word_t want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual index %0d value %h",
                         $time, idx, val);
                $display("%0t:   actual ok %b last %b", $time, ok, last);
                mismatches++;
                return;
            end
            want = expected_words.pop_front();
            if (want.word_index !== idx) begin
                $display("%0t: word_index expected %0d actual %0d", $time, want.word_index, idx);
                mismatches++;
            end
            if (want.word_value !== val) begin
                $display("%0t: word_value expected %h actual %h", $time, want.word_value, val);
                mismatches++;
            end
            if (want.frame_ok !== ok) begin
                $display("%0t: frame_ok expected %b actual %b", $time, want.frame_ok, ok);
                mismatches++;
            end
            if (want.last !== last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_word_index;
    logic [15:0] m_word_value;
    logic        m_frame_ok;
    logic        m_last;

    frame_word_scoreboard sb;
    logic [7:0]  tx_bytes[$];
    int          cycle_count = 0;
    rx_mode_t    rx_mode = RX_ALWAYS;
    int          mode_left = 0;
    int          stall_left = 0;

    particle_sensor_frame_parser_top #(
        .FRAME_BYTES(FB)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word_index(m_word_index),
        .m_word_value(m_word_value),
        .m_frame_ok  (m_frame_ok),
        .m_last      (m_last)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: check each transaction, then pick the next ready value.
    always @(posedge aclk) begin
        logic rdy;
        rdy = 1'b1;
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_word_index, m_word_value, m_frame_ok, m_last);
        if (!aresetn) begin
            rdy = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS: rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = (cycle_count[1:0] == 2'd0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rdy = 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(5, 40);
                    end
                end
            endcase
        end
        m_ready <= rdy;
    end

    // Checksum covers bytes 0 .. FB-3; the last two bytes carry it big-endian.
    function automatic void add_frame(fill_t fill, logic [15:0] csum_flip, bit zero_csum);
        logic [7:0]  b;
        logic [15:0] sum;
        tx_bytes.push_back(PSFP_START_BYTE);
        sum = 16'(PSFP_START_BYTE);
        for (int i = 1; i < FB - 2; i++) begin
            case (fill)
                FILL_ZERO:  b = 8'h00;
                FILL_ONES:  b = 8'hFF;
                FILL_START: b = $urandom_range(0, 1) ? PSFP_START_BYTE : 8'($urandom);
                default:    b = 8'($urandom);
            endcase
            if (i == 1 && fill == FILL_RANDOM && $urandom_range(0, 1)) b = SECOND_HDR;
            tx_bytes.push_back(b);
            sum = sum + 16'(b);
        end
        sum = sum ^ csum_flip;
        if (zero_csum) sum = 16'h0000;
        tx_bytes.push_back(sum[15:8]);
        tx_bytes.push_back(sum[7:0]);
    endfunction

    function automatic void add_noise(int n);
        for (int i = 0; i < n; i++) tx_bytes.push_back(8'($urandom));
    endfunction

    function automatic void build_stimulus();
        int pick;
        // stray bytes while hunting, incl. neighbors of the start byte
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(8'h41);
        tx_bytes.push_back(8'h43);
        tx_bytes.push_back(8'hBD);
        add_frame(FILL_ONES, 16'h0000, 1'b0);
        add_frame(FILL_ZERO, 16'h0000, 1'b0);
        add_frame(FILL_START, 16'h0000, 1'b0);
        add_frame(FILL_RANDOM, 16'h0000, 1'b0);
        add_frame(FILL_RANDOM, 16'h0000, 1'b1);
        add_frame(FILL_ONES, 16'h0001, 1'b0);
        add_frame(FILL_RANDOM, 16'h8000, 1'b0);
        add_frame(FILL_RANDOM, 16'h0000, 1'b0);

        while (tx_bytes.size() < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                case ($urandom_range(0, 9))
                    0:       add_frame(FILL_START, 16'h0000, 1'b0);
                    1:       add_frame(FILL_ONES, 16'h0000, 1'b0);
                    2:       add_frame(FILL_ZERO, 16'h0000, 1'b0);
                    default: add_frame(FILL_RANDOM, 16'h0000, 1'b0);
                endcase
            end else if (pick < 75) begin
                add_frame(FILL_RANDOM, 16'($urandom_range(1, 65535)), 1'b0);
            end else if (pick < 90) begin
                add_noise($urandom_range(1, 8));
            end else begin
                // cut-off frame: the next frame lands inside it
                tx_bytes.push_back(PSFP_START_BYTE);
                add_noise($urandom_range(1, FB - 2));
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        s_rx_byte <= b;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b);
    endtask

    task automatic send_stream();
        int burst_left;
        burst_left = $urandom_range(1, 40);
        for (int k = 0; k < tx_bytes.size(); k++) begin
            send_byte(tx_bytes[k]);
            burst_left--;
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 4)) @(posedge aclk);
                burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
            end
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = 8'h00;
        build_stimulus();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_stream();
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.expected_words.size() != 0) begin
            $display("%0t: %0d results expected but never seen",
                     $time, sb.expected_words.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/psfp_pkg.sv
hw/rtl/psfp_ram.sv
hw/rtl/psfp_dp.sv
hw/rtl/psfp_ctrl.sv
hw/rtl/particle_sensor_frame_parser_top.sv
verif/tb_particle_sensor_frame_parser_top.sv
